[src/qdi_pkg.sv]
// Shared types, codes and the transition decode for the quadrature decoder.
// No dependencies; every other file imports this package.
package qdi_pkg;

  // Widths of the result fields and the default counter width
  localparam int OUT_W               = 32;
  localparam int DEFAULT_COUNT_WIDTH = 32;

  // Event function codes
  localparam logic FUNC_SAMPLE  = 1'b0;
  localparam logic FUNC_PRELOAD = 1'b1;

  // Transition codes {previous A:B, current A:B}: counting down
  localparam logic [3:0] T_00_01 = 4'b0001;
  localparam logic [3:0] T_01_11 = 4'b0111;
  localparam logic [3:0] T_11_10 = 4'b1110;
  localparam logic [3:0] T_10_00 = 4'b1000;
  // Transition codes: counting up
  localparam logic [3:0] T_00_10 = 4'b0010;
  localparam logic [3:0] T_10_11 = 4'b1011;
  localparam logic [3:0] T_11_01 = 4'b1101;
  localparam logic [3:0] T_01_00 = 4'b0100;

  typedef enum logic [1:0] {
    STEP_DEC,
    STEP_INC,
    STEP_ERR
  } step_t;

  typedef struct packed {
    logic              func;
    logic              phase_a;
    logic              phase_b;
    logic              phase_index;
    logic signed [31:0] preload_value;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] position;
    logic signed [OUT_W-1:0] revolutions;
    logic [OUT_W-1:0]        error_total;
  } out_t;

  // Classify one transition code; unchanged and double-step codes are errors
  function automatic step_t decode_step(input logic [3:0] code);
    step_t step;
    unique case (code)
      T_00_01, T_01_11, T_11_10, T_10_00: step = STEP_DEC;
      T_00_10, T_10_11, T_11_01, T_01_00: step = STEP_INC;
      default:                            step = STEP_ERR;
    endcase
    return step;
  endfunction

endpackage

[src/qdi_in_reg.sv]
// Input register stage of the quadrature decoder: holds one accepted event.
// Depends on qdi_pkg for the event payload type.
module qdi_in_reg import qdi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic evt_valid,
  input  logic evt_take,
  output in_t  evt_data
);

  logic vld_r, vld_nxt;
  in_t  data_r;

  // Accept a new event when the stage is empty or drains this cycle
  assign in_ready  = !vld_r || evt_take;
  assign evt_valid = vld_r;
  assign evt_data  = data_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (evt_take) begin
      vld_nxt = 1'b0;
    end
  end

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load the payload on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

[src/qdi_core.sv]
// Decoder core: counter state, transition decode and the result register.
// Depends on qdi_pkg for payload types, codes and decode_step.
module qdi_core import qdi_pkg::*; #(
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic evt_valid,
  output logic evt_take,
  input  in_t  evt_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [1:0]             pair_r, pair_nxt;
  logic [COUNT_WIDTH-1:0] pos_r, pos_nxt;
  logic [COUNT_WIDTH-1:0] rev_r, rev_nxt;
  logic [COUNT_WIDTH-1:0] err_r, err_nxt;
  logic                   out_vld_r, out_vld_nxt;
  out_t                   out_data_r, out_data_nxt;
  logic [1:0]             cur_pair;
  step_t                  step;

  // Take an event whenever the result register is free or being drained
  assign evt_take  = evt_valid && (!out_vld_r || out_ready);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  assign cur_pair = {evt_data.phase_a, evt_data.phase_b};
  assign step     = decode_step({pair_r, cur_pair});

  // Next counter state for the held event
  always_comb begin
    pair_nxt = pair_r;
    pos_nxt  = pos_r;
    rev_nxt  = rev_r;
    err_nxt  = err_r;
    if (evt_take) begin
      unique case (evt_data.func)
        FUNC_PRELOAD: begin
          pos_nxt = COUNT_WIDTH'(evt_data.preload_value);
          rev_nxt = '0;
        end
        FUNC_SAMPLE: begin
          pair_nxt = cur_pair;
          // Index hit only counts in the A=0, B=0 quadrant
          if (evt_data.phase_index && (cur_pair == 2'b00)) begin
            rev_nxt = rev_r + COUNT_WIDTH'(1);
          end
          unique case (step)
            STEP_DEC: pos_nxt = pos_r - COUNT_WIDTH'(1);
            STEP_INC: pos_nxt = pos_r + COUNT_WIDTH'(1);
            STEP_ERR: err_nxt = err_r + COUNT_WIDTH'(1);
          endcase
        end
      endcase
    end
  end

  // Result, cut or extended: position/revolutions signed, errors unsigned
  always_comb begin
    out_data_nxt.position    = OUT_W'($signed(pos_nxt));
    out_data_nxt.revolutions = OUT_W'($signed(rev_nxt));
    out_data_nxt.error_total = OUT_W'(err_nxt);
    out_vld_nxt = out_vld_r;
    if (evt_take) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Advance counter state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_r    <= '0;
      pos_r     <= '0;
      rev_r     <= '0;
      err_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      pair_r    <= pair_nxt;
      pos_r     <= pos_nxt;
      rev_r     <= rev_nxt;
      err_r     <= err_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Load the result payload on each event taken
  always_ff @(posedge clk) begin
    if (evt_take) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

[src/quadrature_decoder_with_index.sv]
// Quadrature decoder (x4) with index revolution counter: top level.
// Depends on qdi_pkg, qdi_in_reg and qdi_core.
//
// Each input transfer is either a sample of the A, B and index lines or a
// preload of the position; every event yields exactly one result transfer
// carrying position, revolutions and error total after that event. An event
// passes the input register and then the decode and counter update into the
// result register, both registered; a result register that is full and not
// drained holds the next event in the input register. One event is taken
// every cycle while the result side keeps draining. Counters are
// COUNT_WIDTH bits wide and wrap; position and revolutions are sign-extended
// or truncated to 32 bits on the result port.
// Reset clears all counters and the last A:B pair.
module quadrature_decoder_with_index import qdi_pkg::*; #(
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic evt_valid;
  logic evt_take;
  in_t  evt_data;

  qdi_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .evt_valid (evt_valid),
    .evt_take  (evt_take),
    .evt_data  (evt_data)
  );

  qdi_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt_take  (evt_take),
    .evt_data  (evt_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
